[hw/rtl/dmp_pkg.sv]
package dmp_pkg;

    localparam int IntegralWidth = 48;
    localparam int GainFracBits  = 16;
    localparam int DegFracBits   = 8;
    localparam int ScaleShift    = 16 - DegFracBits;
    localparam int SumFrac       = GainFracBits + DegFracBits;
    localparam int SumWidth      = 96;
    localparam int PwmFull       = 255;
    localparam int MulSteps      = (IntegralWidth + 15) / 16;
    localparam int MulWidth      = 16 * MulSteps;

    localparam logic [1:0] RegScale = 2'd0;
    localparam logic [1:0] RegGainP = 2'd1;
    localparam logic [1:0] RegGainI = 2'd2;
    localparam logic [1:0] RegGainD = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POS,
        S_ERR,
        S_INC,
        S_INT,
        S_PTERM,
        S_ITERM,
        S_DPROD,
        S_DLOAD,
        S_DIV,
        S_DFIX,
        S_SUM,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [31:0] commanded_position;
        logic [31:0] encoder_count;
        logic [15:0] elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic [7:0] duty;
        logic       direction;
        logic       saturated;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;

endpackage

[hw/rtl/dmp_if.sv]
interface dmp_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/dmp_div.sv]
module dmp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [64:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_busy,
    output logic [64:0] o_quo
);
    import dmp_pkg::*;

    logic [64:0] r_q, n_q;
    logic [16:0] r_rem, n_rem;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [16:0] trial;

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        trial  = '0;
        if (i_start) begin
            n_q    = i_num;
            n_rem  = '0;
            n_cnt  = 7'd65;
            n_busy = 1'b1;
        end else if (r_busy) begin
            trial = {r_rem[15:0], r_q[64]};
            if (trial >= {1'b0, i_den}) begin
                n_rem = trial - {1'b0, i_den};
                n_q   = {r_q[63:0], 1'b1};
            end else begin
                n_rem = trial;
                n_q   = {r_q[63:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_busy = r_busy;
    assign o_quo  = r_q;
endmodule

[hw/rtl/dc_motor_position_pid.sv]
// Channel  | Dir | Payload
// s_in     | in  | commanded_position, encoder_count, elapsed_ms
// m_out    | out | duty, direction, saturated
// cfg      | in  | register index, write data
// Five products go through one shared 32x17 multiplier in turn, plus a bit-serial
// divide of the derivative product by elapsed_ms, skipped when elapsed_ms is zero.
// An item is accepted only in idle, so the next item is not taken until the last
// has reached the output register.
// Input is taken while a result waits; the next item stalls before its sum until
// the waiting result is taken.
// Synchronous active-low reset clears state, gains, integrator, previous error and handshakes; scale resets to 65536.
module dc_motor_position_pid (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    dmp_if.sink         s_in,
    dmp_if.source       m_out
);
    import dmp_pkg::*;

    t_state r_state, n_state;
    logic signed [31:0] r_scale, r_kp, r_ki, r_kd;
    logic signed [31:0] r_cmd, r_cnt, r_err, r_prev;
    logic [15:0] r_dt;
    logic signed [IntegralWidth-1:0] r_integ;
    logic signed [SumWidth-1:0] r_acc, r_prod, r_macc;
    logic signed [64:0] r_inc;
    logic [1:0] r_mcnt;
    logic r_dir, r_ovalid;
    t_out_item r_out;

    logic signed [31:0] ma;
    logic signed [MulWidth-1:0] mb;
    logic [15:0] mlo;
    logic signed [16:0] mchunk;
    logic signed [48:0] mpart;
    logic signed [SumWidth-1:0] mbase, mshift, mprod;
    logic mul_step, mul_last;
    logic signed [64:0] pos_w, err_w;
    logic signed [IntegralWidth+1:0] isum;
    logic signed [IntegralWidth+1:0] imax, imin;
    logic [64:0] dmag, qmag;
    logic dneg;
    t_div_ctl dc;
    logic signed [SumWidth-1:0] lim, pwm;
    logic [SumWidth-1:0] mag;

    assign lim  = SumWidth'(PwmFull) <<< SumFrac;
    assign imax = (IntegralWidth+2)'({1'b0, {(IntegralWidth-1){1'b1}}});
    assign imin = -imax - 1;

    assign mul_step = r_state inside {S_POS, S_INC, S_PTERM, S_ITERM, S_DPROD};
    assign mul_last = mul_step && (r_mcnt == 2'(MulSteps - 1));

    // shared multiplier: 16 bits of the second operand per cycle, top slice signed
    always_comb begin
        ma = '0;
        mb = '0;
        case (r_state)
            S_POS:   begin ma = r_cnt; mb = MulWidth'(r_scale); end
            S_INC:   begin ma = r_err; mb = MulWidth'(r_dt); end
            S_PTERM: begin ma = r_kp;  mb = MulWidth'(r_err); end
            S_ITERM: begin ma = r_ki;  mb = MulWidth'(r_integ); end
            S_DPROD: begin ma = r_kd;  mb = MulWidth'(r_err) - MulWidth'(r_prev); end
            default: begin ma = '0;    mb = '0; end
        endcase
        mlo    = mb[16*r_mcnt +: 16];
        mchunk = (r_mcnt == 2'(MulSteps - 1)) ? $signed({mlo[15], mlo})
                                              : $signed({1'b0, mlo});
        mpart  = ma * mchunk;
        mshift = SumWidth'(mpart) <<< (16 * r_mcnt);
        mbase  = (r_mcnt == 2'd0) ? '0 : r_macc;
        mprod  = mbase + mshift;
    end

    assign pos_w = 65'(r_prod >>> ScaleShift);
    assign err_w = 65'(r_cmd) - pos_w;
    assign isum  = (IntegralWidth+2)'(r_integ) + (IntegralWidth+2)'(r_inc);
    assign dneg  = r_prod[SumWidth-1];
    assign dmag  = dneg ? 65'(-r_prod) : 65'(r_prod);
    assign dc.start = (r_state == S_DLOAD) && (r_dt != 16'd0);

    dmp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dc.start),
        .i_num(dmag), .i_den(r_dt), .o_busy(dc.busy), .o_quo(qmag)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (s_in.valid) n_state = S_POS;
            S_POS:   if (mul_last) n_state = S_ERR;
            S_ERR:   n_state = S_INC;
            S_INC:   if (mul_last) n_state = S_INT;
            S_INT:   n_state = S_PTERM;
            S_PTERM: if (mul_last) n_state = S_ITERM;
            S_ITERM: if (mul_last) n_state = S_DPROD;
            S_DPROD: if (mul_last) n_state = S_DLOAD;
            S_DLOAD: n_state = S_DIV;
            S_DIV:   if (!dc.busy) n_state = S_DFIX;
            S_DFIX:  n_state = S_SUM;
            S_SUM:   if (!r_ovalid) n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (r_acc > lim) pwm = lim;
        else if (r_acc < -lim) pwm = -lim;
        else pwm = r_acc;
        mag = pwm[SumWidth-1] ? SumWidth'(-pwm) : SumWidth'(pwm);
    end

    assign s_in.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_scale  <= 32'sd65536;
            r_kp     <= '0;
            r_ki     <= '0;
            r_kd     <= '0;
            r_prev   <= '0;
            r_integ  <= '0;
            r_dir    <= 1'b0;
            r_ovalid <= 1'b0;
            r_mcnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    RegScale: r_scale <= i_cfg_data;
                    RegGainP: r_kp    <= i_cfg_data;
                    RegGainI: r_ki    <= i_cfg_data;
                    RegGainD: r_kd    <= i_cfg_data;
                    default:  ;
                endcase
            end
            if (mul_step) begin
                r_macc <= mprod;
                r_mcnt <= mul_last ? 2'd0 : r_mcnt + 2'd1;
            end
            if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (s_in.valid) begin
                    r_cmd <= s_in.data.commanded_position;
                    r_cnt <= s_in.data.encoder_count;
                    r_dt  <= s_in.data.elapsed_ms;
                end
                S_POS: if (mul_last) r_prod <= mprod;
                S_ERR: begin
                    if (err_w > 65'sh7FFFFFFF) r_err <= 32'h7FFFFFFF;
                    else if (err_w < -65'sh80000000) r_err <= 32'h80000000;
                    else r_err <= err_w[31:0];
                end
                S_INC: if (mul_last) r_inc <= mprod[64:0];
                S_INT: begin
                    if (isum > imax) r_integ <= imax[IntegralWidth-1:0];
                    else if (isum < imin) r_integ <= imin[IntegralWidth-1:0];
                    else r_integ <= isum[IntegralWidth-1:0];
                end
                S_PTERM: if (mul_last) r_acc <= mprod;
                S_ITERM: if (mul_last) r_acc <= r_acc + mprod;
                S_DPROD: if (mul_last) r_prod <= mprod;
                S_DFIX: begin
                    if (r_dt != 16'd0)
                        r_acc <= r_acc + (dneg ? -SumWidth'(qmag) : SumWidth'(qmag));
                    r_prev <= r_err;
                end
                S_SUM: if (!r_ovalid) begin
                    if (pwm > 0) r_dir <= 1'b1;
                    else if (pwm < 0) r_dir <= 1'b0;
                    r_out.duty      <= mag[SumFrac +: 8];
                    r_out.saturated <= (r_acc > lim) || (r_acc < -lim);
                end
                S_OUT: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    assign m_out.valid = r_ovalid;
    assign m_out.data  = '{duty: r_out.duty, direction: r_dir, saturated: r_out.saturated};
endmodule
